FILE: rtl/lzwd_pkg.sv
package lzwd_pkg;

    localparam int LIMIT_W          = 24;
    localparam int DEF_WINDOW_DEPTH = 2048;
    localparam int DEF_LENGTH_BITS  = 24;
    localparam int OFS_BITS         = 11;
    localparam int COPY_CNT_W       = 8;

    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 24'hFF_FFFF;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       segment_last;
    } in_t;

    typedef struct packed {
        logic [31:0]        out_word;
        logic [2:0]         byte_count;
        logic               run_last;
        logic               segment_end;
        logic [LIMIT_W-1:0] decoded_length;
    } out_t;

endpackage

FILE: rtl/lz_window_decompressor_core.sv
// Channel   Direction  Handshake            Payload
// in        sink       in_valid/in_ready    lzwd_pkg::in_t  (one compressed byte)
// out       source     out_valid/out_ready  lzwd_pkg::out_t (one output word or end marker)
// cfg       sink       cfg_valid/cfg_ready  out_limit, 24 bits
//
// Flag bytes, literal bytes and the first byte of a match are accepted in the idle state.
// After the second byte of a match, a copy of 1 to 128 bytes runs one byte
// per cycle through the history memory port, with the input channel closed.
// The end-of-segment marker after a completed literal or a match is sent from the end state.
// Reset clears all control state and sets the limit to its maximum; history is not cleared.
// A stalled output holds the copy at its next word boundary.
module lz_window_decompressor_core #(
    parameter int WINDOW_DEPTH = lzwd_pkg::DEF_WINDOW_DEPTH,
    parameter int LENGTH_BITS  = lzwd_pkg::DEF_LENGTH_BITS
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  lzwd_pkg::in_t                 in_data,
    output logic                          out_valid,
    input  logic                          out_ready,
    output lzwd_pkg::out_t                out_data,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [lzwd_pkg::LIMIT_W-1:0]  cfg_data
);
    import lzwd_pkg::*;

    localparam int ADDR_W = $clog2(WINDOW_DEPTH);
    localparam int CNT_W  = (LENGTH_BITS < LIMIT_W) ? LENGTH_BITS : LIMIT_W;
    localparam logic [LIMIT_W-1:0] LIM_CAP = LIMIT_W'((64'd1 << CNT_W) - 64'd1);
    localparam logic [ADDR_W:0]    DEPTH_X = (ADDR_W + 1)'(WINDOW_DEPTH);

    typedef enum logic [1:0] {S_IDLE, S_COPY, S_END} state_t;

    state_t                  state_reg, state_next;
    logic [LIMIT_W-1:0]      out_limit_reg, out_limit_next;
    logic [ADDR_W-1:0]       wp_reg, wp_next;
    logic [CNT_W-1:0]        produced_reg, produced_next;
    logic [7:0]              flag_bits_reg, flag_bits_next;
    logic [2:0]              flag_idx_reg, flag_idx_next;
    logic                    need_flag_reg, need_flag_next;
    logic [1:0]              phase_reg, phase_next;
    logic [23:0]             hold_reg, hold_next;
    logic [ADDR_W-1:0]       rp_reg, rp_next;
    logic [COPY_CNT_W-1:0]   left_reg, left_next;
    logic [1:0]              lane_reg, lane_next;
    logic [23:0]             acc_reg, acc_next;
    logic                    zero_src_reg, zero_src_next;
    logic                    end_pend_reg, end_pend_next;
    logic                    out_valid_reg, out_valid_next;
    out_t                    out_data_reg;

    logic [7:0]              hist_mem [WINDOW_DEPTH];
    logic [7:0]              rd_data_reg;
    logic                    fwd_reg;
    logic [7:0]              fwd_data_reg;

    logic                    mem_we;
    logic [ADDR_W-1:0]       mem_waddr;
    logic [7:0]              mem_wdata;
    logic [ADDR_W-1:0]       rd_addr;

    logic [LIMIT_W-1:0]      lim;
    logic [CNT_W-1:0]        lim_c;
    logic                    room_zero;
    logic [CNT_W-1:0]        room;
    logic                    slot_free;
    logic                    accept;
    logic                    is_match;
    logic [15:0]             mtok;
    logic [OFS_BITS-1:0]     ofs_raw;
    logic [OFS_BITS-1:0]     ofs_c;
    logic [COPY_CNT_W-1:0]   mcnt;
    logic [COPY_CNT_W-1:0]   mcnt_c;
    logic [ADDR_W-1:0]       src_start;
    logic [2:0]              lit_cnt;
    logic [31:0]             lit_raw;
    logic [31:0]             lit_word;
    logic [7:0]              cbyte;
    logic                    word_done;
    logic                    emit;
    out_t                    emit_data;
    logic                    seg_clear;
    logic                    tok_done;
    logic                    go_copy;

    function automatic logic [ADDR_W-1:0] addr_add(input logic [ADDR_W-1:0] a,
                                                   input logic [ADDR_W-1:0] k);
        logic [ADDR_W:0] s;
        s = {1'b0, a} + {1'b0, k};
        if (s >= DEPTH_X)
        begin
            s = s - DEPTH_X;
        end
        return s[ADDR_W-1:0];
    endfunction

    function automatic logic [ADDR_W-1:0] addr_sub(input logic [ADDR_W-1:0] a,
                                                   input logic [ADDR_W-1:0] d);
        logic [ADDR_W:0] s;
        if (a >= d)
        begin
            s = {1'b0, a} - {1'b0, d};
        end
        else
        begin
            s = {1'b0, a} + DEPTH_X - {1'b0, d};
        end
        return s[ADDR_W-1:0];
    endfunction

    // Derived token and limit values.
    always_comb
    begin
        lim       = (out_limit_reg > LIM_CAP) ? LIM_CAP : out_limit_reg;
        lim_c     = lim[CNT_W-1:0];
        room_zero = (produced_reg >= lim_c);
        room      = room_zero ? '0 : (lim_c - produced_reg);
        slot_free = !out_valid_reg || out_ready;
        in_ready  = (state_reg == S_IDLE) && slot_free;
        accept    = in_valid && in_ready;
        is_match  = flag_bits_reg[3'd7 - flag_idx_reg];
        mtok      = {in_data.in_byte, hold_reg[7:0]};
        ofs_raw   = mtok[OFS_BITS-1:0];
        ofs_c     = (CNT_W'(ofs_raw) > produced_reg) ? produced_reg[OFS_BITS-1:0] : ofs_raw;
        mcnt      = (COPY_CNT_W'(mtok[15:OFS_BITS]) + COPY_CNT_W'(1)) << 2;
        mcnt_c    = (room < CNT_W'(mcnt)) ? room[COPY_CNT_W-1:0] : mcnt;
        src_start = addr_sub(wp_reg, ADDR_W'(ofs_c));
        lit_cnt   = (room < CNT_W'(4)) ? room[2:0] : 3'd4;
        lit_raw   = {in_data.in_byte, hold_reg};
        lit_word  = '0;
        for (int i = 0; i < 4; i++)
        begin
            if (3'(i) < lit_cnt)
            begin
                lit_word[8*i +: 8] = lit_raw[8*i +: 8];
            end
        end
        cbyte     = zero_src_reg ? 8'd0 : (fwd_reg ? fwd_data_reg : rd_data_reg);
        word_done = (lane_reg == 2'd3) || (left_reg == COPY_CNT_W'(1));
    end

    always_comb
    begin
        state_next     = state_reg;
        out_limit_next = out_limit_reg;
        wp_next        = wp_reg;
        produced_next  = produced_reg;
        flag_bits_next = flag_bits_reg;
        flag_idx_next  = flag_idx_reg;
        need_flag_next = need_flag_reg;
        phase_next     = phase_reg;
        hold_next      = hold_reg;
        rp_next        = rp_reg;
        left_next      = left_reg;
        lane_next      = lane_reg;
        acc_next       = acc_reg;
        zero_src_next  = zero_src_reg;
        end_pend_next  = end_pend_reg;
        mem_we         = 1'b0;
        mem_waddr      = wp_reg;
        mem_wdata      = in_data.in_byte;
        rd_addr        = rp_reg;
        emit           = 1'b0;
        emit_data      = '0;
        seg_clear      = 1'b0;
        tok_done       = 1'b0;
        go_copy        = 1'b0;

        if (cfg_valid)
        begin
            out_limit_next = cfg_data;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                rd_addr = src_start;
                if (accept)
                begin
                    if (!room_zero)
                    begin
                        if (need_flag_reg)
                        begin
                            flag_bits_next = in_data.in_byte;
                            flag_idx_next  = '0;
                            need_flag_next = 1'b0;
                            phase_next     = '0;
                            hold_next      = '0;
                        end
                        else if (!is_match)
                        begin
                            // Literal bytes go straight to the window; no copy can
                            // read those slots before the literal completes.
                            if (room > CNT_W'(phase_reg))
                            begin
                                mem_we    = 1'b1;
                                mem_waddr = addr_add(wp_reg, ADDR_W'(phase_reg));
                            end
                            if (phase_reg != 2'd3)
                            begin
                                hold_next[8*phase_reg +: 8] = in_data.in_byte;
                                phase_next = phase_reg + 2'd1;
                            end
                            else
                            begin
                                emit                 = 1'b1;
                                emit_data.out_word   = lit_word;
                                emit_data.byte_count = lit_cnt;
                                emit_data.run_last   = !in_data.segment_last;
                                wp_next       = addr_add(wp_reg, ADDR_W'(lit_cnt));
                                produced_next = produced_reg + CNT_W'(lit_cnt);
                                tok_done      = 1'b1;
                            end
                        end
                        else if (phase_reg == 2'd0)
                        begin
                            hold_next  = {16'd0, in_data.in_byte};
                            phase_next = 2'd1;
                        end
                        else
                        begin
                            go_copy       = 1'b1;
                            state_next    = S_COPY;
                            rp_next       = src_start;
                            left_next     = mcnt_c;
                            lane_next     = '0;
                            acc_next      = '0;
                            zero_src_next = (ofs_c == '0);
                            end_pend_next = in_data.segment_last;
                            tok_done      = 1'b1;
                        end
                    end
                    if (in_data.segment_last && !go_copy)
                    begin
                        if (emit)
                        begin
                            state_next = S_END;
                        end
                        else
                        begin
                            emit                     = 1'b1;
                            emit_data.run_last       = 1'b1;
                            emit_data.segment_end    = 1'b1;
                            emit_data.decoded_length = LIMIT_W'(produced_reg);
                            seg_clear                = 1'b1;
                        end
                    end
                end
            end

            S_COPY:
            begin
                // A word boundary needs a free output slot; otherwise the same source
                // byte is read again so the pipeline restarts cleanly.
                if (!word_done || slot_free)
                begin
                    mem_we        = 1'b1;
                    mem_waddr     = wp_reg;
                    mem_wdata     = cbyte;
                    wp_next       = addr_add(wp_reg, ADDR_W'(1));
                    produced_next = produced_reg + CNT_W'(1);
                    rp_next       = addr_add(rp_reg, ADDR_W'(1));
                    rd_addr       = rp_next;
                    left_next     = left_reg - COPY_CNT_W'(1);
                    lane_next     = lane_reg + 2'd1;
                    acc_next      = acc_reg | (24'(cbyte) << (8 * lane_reg));
                    if (word_done)
                    begin
                        emit                 = 1'b1;
                        emit_data.out_word   = 32'(acc_reg) | (32'(cbyte) << (8 * lane_reg));
                        emit_data.byte_count = 3'(lane_reg) + 3'd1;
                        emit_data.run_last   = (left_reg == COPY_CNT_W'(1)) && !end_pend_reg;
                        acc_next             = '0;
                        lane_next            = '0;
                    end
                    if (left_reg == COPY_CNT_W'(1))
                    begin
                        state_next = end_pend_reg ? S_END : S_IDLE;
                    end
                end
            end

            S_END:
            begin
                if (slot_free)
                begin
                    emit                     = 1'b1;
                    emit_data.run_last       = 1'b1;
                    emit_data.segment_end    = 1'b1;
                    emit_data.decoded_length = LIMIT_W'(produced_reg);
                    seg_clear                = 1'b1;
                    state_next               = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (tok_done)
        begin
            phase_next = '0;
            hold_next  = '0;
            if (flag_idx_reg == 3'd7)
            begin
                flag_idx_next  = '0;
                need_flag_next = 1'b1;
            end
            else
            begin
                flag_idx_next = flag_idx_reg + 3'd1;
            end
        end

        if (seg_clear)
        begin
            wp_next        = '0;
            produced_next  = '0;
            flag_bits_next = '0;
            flag_idx_next  = '0;
            need_flag_next = 1'b1;
            phase_next     = '0;
            hold_next      = '0;
        end

        if (emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_limit_reg <= LIMIT_RESET;
            wp_reg        <= '0;
            produced_reg  <= '0;
            flag_bits_reg <= '0;
            flag_idx_reg  <= '0;
            need_flag_reg <= 1'b1;
            phase_reg     <= '0;
            hold_reg      <= '0;
            rp_reg        <= '0;
            left_reg      <= '0;
            lane_reg      <= '0;
            acc_reg       <= '0;
            zero_src_reg  <= 1'b0;
            end_pend_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_limit_reg <= out_limit_next;
            wp_reg        <= wp_next;
            produced_reg  <= produced_next;
            flag_bits_reg <= flag_bits_next;
            flag_idx_reg  <= flag_idx_next;
            need_flag_reg <= need_flag_next;
            phase_reg     <= phase_next;
            hold_reg      <= hold_next;
            rp_reg        <= rp_next;
            left_reg      <= left_next;
            lane_reg      <= lane_next;
            acc_reg       <= acc_next;
            zero_src_reg  <= zero_src_next;
            end_pend_reg  <= end_pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            out_data_reg <= emit_data;
        end
    end

    // History window. A read that hits the entry written in the same cycle takes the
    // write data on the next cycle, which covers copies with an offset of one.
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            hist_mem[mem_waddr] <= mem_wdata;
        end
        rd_data_reg  <= hist_mem[rd_addr];
        fwd_reg      <= mem_we && (mem_waddr == rd_addr);
        fwd_data_reg <= mem_wdata;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;
    assign cfg_ready = 1'b1;

    a_copy_has_work: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_COPY |-> left_reg != '0)
        else $error("copy running with no bytes left");

    a_end_marker_shape: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_data_reg.segment_end |->
            out_data_reg.byte_count == 3'd0 && out_data_reg.run_last &&
            out_data_reg.out_word == 32'd0)
        else $error("malformed end-of-segment transaction");

    a_word_count: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !out_data_reg.segment_end |->
            out_data_reg.byte_count != 3'd0 && out_data_reg.byte_count <= 3'd4)
        else $error("output word with bad byte count");

    a_wp_in_window: assert property (@(posedge clk) disable iff (!rst_n)
        {1'b0, wp_reg} < DEPTH_X && {1'b0, rp_reg} < DEPTH_X)
        else $error("window pointer out of range");

    a_segment_restart: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_END && slot_free |=> produced_reg == '0 && need_flag_reg)
        else $error("segment state not cleared after end marker");

endmodule

FILE: sim/testbench.sv
`timescale 1ns / 100ps

module testbench;
    import lzwd_pkg::*;

    localparam int PTR_W         = $clog2(DEF_WINDOW_DEPTH);
    localparam int SETTLE_CYCLES = 16;
    localparam int QUIET_LIMIT   = 2000;
    localparam int RANDOM_ITEMS  = 400;

    logic               clk       = 1'b0;
    logic               rst_n     = 1'b0;
    logic               in_valid  = 1'b0;
    logic               in_ready;
    in_t                in_data   = '0;
    logic               out_valid;
    logic               out_ready = 1'b0;
    out_t               out_data;
    logic               cfg_valid = 1'b0;
    logic               cfg_ready;
    logic [LIMIT_W-1:0] cfg_data  = '0;

    // Shadow copy of the decoder state.
    logic [7:0]         history_mem [DEF_WINDOW_DEPTH];
    logic [PTR_W-1:0]   wr_pos;
    logic [LIMIT_W-1:0] produced;
    logic [7:0]         flags;
    logic [2:0]         flag_idx;
    logic               want_flag;
    logic [1:0]         tok_phase;
    logic [23:0]        tok_hold;
    logic [LIMIT_W-1:0] limit_reg;

    out_t pending_words[$];
    out_t want_word;
    int   errors       = 0;
    int   quiet_cycles = 0;
    int   live_items   = 0;
    bit   no_gaps      = 1'b0;

    lz_window_decompressor_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    function automatic void clear_segment();
        wr_pos    = '0;
        produced  = '0;
        flags     = '0;
        flag_idx  = '0;
        want_flag = 1'b1;
        tok_phase = '0;
        tok_hold  = '0;
    endfunction

    function automatic logic [LIMIT_W-1:0] room_left_bytes();
        return (produced < limit_reg) ? limit_reg - produced : '0;
    endfunction

    function automatic void store_byte(logic [7:0] b);
        history_mem[wr_pos] = b;
        wr_pos   = wr_pos + 1'b1;
        produced = produced + 1'b1;
    endfunction

    function automatic void close_token();
        tok_phase = '0;
        tok_hold  = '0;
        if (flag_idx == 3'd7)
        begin
            flag_idx  = '0;
            want_flag = 1'b1;
        end
        else
        begin
            flag_idx = flag_idx + 1'b1;
        end
    endfunction

    function automatic out_t data_word(logic [31:0] w, int n);
        out_t r;
        r            = '0;
        r.out_word   = w;
        r.byte_count = 3'(n);
        return r;
    endfunction

    // Works out the words that one accepted compressed byte produces.
    function automatic void decode_byte(in_t item);
        out_t              batch[$];
        out_t              marker;
        logic [7:0]        b;
        logic [7:0]        bt;
        logic [31:0]       word;
        logic [15:0]       code;
        logic [OFS_BITS-1:0] ofs;
        logic [PTR_W-1:0]  rd;
        int                cnt;
        int                room;
        int                i;
        b    = item.in_byte;
        room = int'(room_left_bytes());
        live_items++;
        if (room != 0)
        begin
            if (want_flag)
            begin
                flags     = b;
                flag_idx  = '0;
                want_flag = 1'b0;
                tok_phase = '0;
                tok_hold  = '0;
            end
            else if (!flags[3'd7 - flag_idx])
            begin
                if (tok_phase < 2'd3)
                begin
                    tok_hold[8*tok_phase +: 8] = b;
                    tok_phase = tok_phase + 1'b1;
                end
                else
                begin
                    word = {b, tok_hold};
                    cnt  = (room < 4) ? room : 4;
                    for (i = 0; i < cnt; i++)
                        store_byte(word[8*i +: 8]);
                    for (i = cnt; i < 4; i++)
                        word[8*i +: 8] = 8'h00;
                    batch.push_back(data_word(word, cnt));
                    close_token();
                end
            end
            else if (tok_phase == 2'd0)
            begin
                tok_hold  = {16'h0000, b};
                tok_phase = 2'd1;
            end
            else
            begin
                code = {b, tok_hold[7:0]};
                ofs  = code[OFS_BITS-1:0];
                if (ofs > produced)
                    ofs = produced[OFS_BITS-1:0];
                cnt = (int'(code[15:OFS_BITS]) + 1) * 4;
                if (cnt > room)
                    cnt = room;
                word = '0;
                // Read after each write so that overlapping copies repeat the pattern.
                for (i = 0; i < cnt; i++)
                begin
                    rd = wr_pos - ofs;
                    bt = (ofs == 0) ? 8'h00 : history_mem[rd];
                    store_byte(bt);
                    word[8*(i%4) +: 8] = bt;
                    if ((i % 4) == 3 || i + 1 == cnt)
                    begin
                        batch.push_back(data_word(word, (i % 4) + 1));
                        word = '0;
                    end
                end
                close_token();
            end
        end
        if (item.segment_last)
        begin
            marker                = '0;
            marker.segment_end    = 1'b1;
            marker.decoded_length = produced;
            batch.push_back(marker);
            clear_segment();
        end
        if (batch.size() > 0)
            batch[batch.size()-1].run_last = 1'b1;
        foreach (batch[k])
            pending_words.push_back(batch[k]);
    endfunction

    function automatic void compare_field(string field, logic [31:0] want, logic [31:0] got);
        if (want !== got)
        begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, field, want, got);
            errors++;
        end
    endfunction

    initial
    begin
        foreach (history_mem[k])
            history_mem[k] = 8'h00;
        clear_segment();
        limit_reg = LIMIT_RESET;
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && in_ready)
                decode_byte(in_data);
            if (cfg_valid && cfg_ready)
                limit_reg = cfg_data;
            if (out_valid && out_ready)
            begin
                if (pending_words.size() == 0)
                begin
                    $display("%0t: unexpected result, expected none, actual %h", $time, out_data);
                    errors++;
                end
                else
                begin
                    want_word = pending_words.pop_front();
                    compare_field("out_word", want_word.out_word, out_data.out_word);
                    compare_field("byte_count", want_word.byte_count, out_data.byte_count);
                    compare_field("run_last", want_word.run_last, out_data.run_last);
                    compare_field("segment_end", want_word.segment_end, out_data.segment_end);
                    compare_field("decoded_length", want_word.decoded_length,
                                  out_data.decoded_length);
                end
            end
            if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
    end

    initial
    begin
        wait (rst_n);
        while (quiet_cycles < QUIET_LIMIT)
            @(posedge clk);
        $display("testbench: errors");
        $finish;
    end

    function automatic int pick_gap();
        int r;
        if (no_gaps)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Output back-pressure runs on its own for the whole run.
    initial
    begin
        int stall;
        @(posedge clk);
        forever
        begin
            stall = pick_gap();
            if (stall > 0)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ready <= 1'b1;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
    end

    // Valid stays up from one transaction to the next when no gap is taken.
    task automatic send_byte(input logic [7:0] b, input logic last);
        in_t item;
        int  gap;
        gap               = pick_gap();
        item.in_byte      = b;
        item.segment_last = last;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_data  <= item;
        in_valid <= 1'b1;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
    endtask

    task automatic send_bytes(input logic [7:0] bytes[$], input logic last_on_end);
        foreach (bytes[k])
            send_byte(bytes[k], last_on_end && (k == bytes.size() - 1));
    endtask

    task automatic wait_for_idle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_words.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_limit(input logic [LIMIT_W-1:0] value);
        cfg_data  <= value;
        cfg_valid <= 1'b1;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic test_single_byte_segment();
        send_byte(8'hFF, 1'b1);
    endtask

    // Clamped zero-offset match, extreme literal bytes, longest overlapping copy,
    // then half a match dropped by the end of the segment.
    task automatic test_literal_and_match_tokens();
        send_bytes('{8'hBF, 8'h05, 8'h00, 8'h00, 8'hFF, 8'h80, 8'h7F,
                     8'h01, 8'hF8, 8'hFF}, 1'b1);
    endtask

    task automatic test_match_clipped_at_limit();
        wait_for_idle();
        write_limit(24'd6);
        send_bytes('{8'h40, 8'h01, 8'h02, 8'h03, 8'h04, 8'h02, 8'h08, 8'hAA}, 1'b1);
    endtask

    task automatic test_limit_lowered_mid_segment();
        wait_for_idle();
        write_limit(LIMIT_RESET);
        send_bytes('{8'h00, 8'h9C, 8'h3E, 8'hD1, 8'h66}, 1'b0);
        wait_for_idle();
        write_limit(24'd1);
        send_byte(8'h55, 1'b1);
    endtask

    task automatic test_literal_clipped_at_limit();
        send_bytes('{8'h00, 8'hAB, 8'hCD, 8'hEF, 8'h12}, 1'b1);
    endtask

    function automatic logic [LIMIT_W-1:0] pick_limit();
        int r;
        r = $urandom_range(0, 9);
        if (r < 3)
            return LIMIT_W'($urandom_range(1, 300));
        if (r == 3)
            return LIMIT_W'($urandom_range(1, 24'hFF_FFFF));
        if (r == 4)
            return 24'd1;
        return LIMIT_RESET;
    endfunction

    // Mostly well-formed segments with random content, some of them long enough
    // to wrap the window, plus noise and segments cut off mid-token.
    task automatic run_random_segment();
        logic [7:0]  seg_bytes[$];
        logic [7:0]  flag;
        logic [15:0] code;
        int          kind;
        int          ntok;
        int          made;
        int          units;
        int          ofs;
        int          bound;
        int          cut;
        int          cfg_at;
        kind    = $urandom_range(0, 19);
        no_gaps = ($urandom_range(0, 4) == 0);
        made    = 0;
        flag    = '0;
        if (kind == 1)
        begin
            repeat ($urandom_range(1, 12))
                seg_bytes.push_back(8'($urandom_range(0, 255)));
        end
        else
        begin
            ntok = (kind == 0) ? $urandom_range(16, 40) : $urandom_range(1, 20);
            for (int t = 0; t < ntok; t++)
            begin
                if (t % 8 == 0)
                begin
                    if (kind == 0 && $urandom_range(0, 3) != 0)
                        flag = 8'hFF;
                    else
                        flag = 8'($urandom_range(0, 255));
                    seg_bytes.push_back(flag);
                end
                if (flag[7 - (t % 8)])
                begin
                    if (kind == 0)
                        units = $urandom_range(16, 31);
                    else if ($urandom_range(0, 7) == 0)
                        units = $urandom_range(0, 31);
                    else
                        units = $urandom_range(0, 3);
                    bound = (made < 2047) ? made : 2047;
                    if (bound < 1)
                        bound = 1;
                    case ($urandom_range(0, 9))
                        0:       ofs = 0;
                        1:       ofs = $urandom_range(0, 2047);
                        2:       ofs = bound;
                        default: ofs = $urandom_range(1, bound);
                    endcase
                    code = 16'((units << OFS_BITS) | ofs);
                    seg_bytes.push_back(code[7:0]);
                    seg_bytes.push_back(code[15:8]);
                    made += (units + 1) * 4;
                end
                else
                begin
                    repeat (4)
                        seg_bytes.push_back(8'($urandom_range(0, 255)));
                    made += 4;
                end
            end
            if (kind == 2 || kind == 3)
            begin
                cut = $urandom_range(1, seg_bytes.size());
                while (seg_bytes.size() > cut)
                    void'(seg_bytes.pop_back());
            end
        end
        if ($urandom_range(0, 2) == 0)
        begin
            wait_for_idle();
            write_limit(pick_limit());
        end
        cfg_at = -1;
        if (seg_bytes.size() > 1 && $urandom_range(0, 7) == 0)
            cfg_at = $urandom_range(1, seg_bytes.size() - 1);
        foreach (seg_bytes[k])
        begin
            if (k == cfg_at)
            begin
                wait_for_idle();
                write_limit(($urandom_range(0, 1) == 0) ? LIMIT_W'($urandom_range(1, made + 1))
                                                        : LIMIT_RESET);
            end
            send_byte(seg_bytes[k], k == seg_bytes.size() - 1);
        end
    endtask

    task automatic test_random_segments();
        int start;
        start = live_items;
        while (live_items < start + RANDOM_ITEMS)
            run_random_segment();
        no_gaps = 1'b0;
    endtask

    initial
    begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        test_single_byte_segment();
        test_literal_and_match_tokens();
        test_match_clipped_at_limit();
        test_limit_lowered_mid_segment();
        test_literal_clipped_at_limit();
        test_random_segments();
        wait_for_idle();
        if (errors == 0)
            $display("testbench: clean");
        else
            $display("testbench: errors");
        $finish;
    end

endmodule
